@@ rtl/assert_macros.svh @@
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define CDQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent on the following edge
`define CDQ_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/cdq_pkg.sv @@
package cdq_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int ITEM_WIDTH_DEFAULT = 32;
    localparam int CAP_W              = 5;
    localparam int COUNT_W            = 5;
    localparam int KIND_W             = 3;
    localparam int STATUS_W           = 2;
    localparam int CAP_RESET          = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_TAIL = 3'd0,
        KIND_PUSH_HEAD = 3'd1,
        KIND_POP_TAIL  = 3'd2,
        KIND_POP_HEAD  = 3'd3,
        KIND_PEEK_TAIL = 3'd4,
        KIND_PEEK_HEAD = 3'd5
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_ZERO  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // zero acts as one, anything above the ring depth acts as the depth
    function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] cap, input int depth);
        logic [CAP_W-1:0] res;
        res = cap;
        if (cap == '0)
        begin
            res = CAP_W'(1);
        end
        else if (int'(cap) > depth)
        begin
            res = CAP_W'(depth);
        end
        return res;
    endfunction

endpackage

@@ rtl/circular_deque.sv @@
// a request accepted at one edge shows its result, with done high, in the next cycle
// busy stays high while the result is shown, and no new request is taken until busy drops
// the result is read from the single ring memory through its registered read port
// reset: queue empty, pointers at zero, capacity 16 (clamped to the depth), no result pending
// the receiver cannot stall, each result is valid for exactly one cycle
`include "assert_macros.svh"

module circular_deque #(
    parameter int DEPTH      = cdq_pkg::DEPTH_DEFAULT,
    parameter int ITEM_WIDTH = cdq_pkg::ITEM_WIDTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [cdq_pkg::KIND_W-1:0]   kind,
    input  logic [ITEM_WIDTH-1:0]        value,
    output logic                         done,
    output logic [cdq_pkg::STATUS_W-1:0] status,
    output logic [ITEM_WIDTH-1:0]        item_out,
    output logic [cdq_pkg::COUNT_W-1:0]  count,
    output logic                         is_empty,
    output logic                         is_full,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [cdq_pkg::CAP_W-1:0]    cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW = ((AW > cdq_pkg::CAP_W) ? AW : cdq_pkg::CAP_W) + 1;

    logic [cdq_pkg::CAP_W-1:0]   cap_reg, cap_next;
    logic [AW-1:0]               head_reg, head_next;
    logic [AW-1:0]               tail_reg, tail_next;
    logic [cdq_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                        done_reg;
    cdq_pkg::status_t            status_reg, status_next;
    logic                        item_ok_reg, item_ok_next;

    logic                        accept;
    logic                        cfg_fire;
    logic                        q_empty;
    logic                        q_full;
    logic                        val_zero;
    logic [XW-1:0]               cap_ext;
    logic [XW-1:0]               head_plus;
    logic [XW-1:0]               tail_plus;
    logic [AW-1:0]               head_inc, head_dec;
    logic [AW-1:0]               tail_inc, tail_dec;

    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [ITEM_WIDTH-1:0]       rd_data;

    assign busy      = done_reg;
    assign cfg_ready = !done_reg && !start;
    assign accept    = start && !done_reg;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign q_empty  = (count_reg == '0);
    assign q_full   = (count_reg >= cap_reg);
    assign val_zero = (value == '0);

    // ring neighbors, wrapping at the capacity
    assign cap_ext   = XW'(cap_reg);
    assign head_plus = XW'(head_reg) + XW'(1);
    assign tail_plus = XW'(tail_reg) + XW'(1);
    assign head_inc  = (head_plus >= cap_ext) ? '0 : AW'(head_plus);
    assign tail_inc  = (tail_plus >= cap_ext) ? '0 : AW'(tail_plus);
    assign head_dec  = (head_reg == '0 || XW'(head_reg) >= cap_ext)
                       ? AW'(cap_ext - XW'(1)) : AW'(XW'(head_reg) - XW'(1));
    assign tail_dec  = (tail_reg == '0 || XW'(tail_reg) >= cap_ext)
                       ? AW'(cap_ext - XW'(1)) : AW'(XW'(tail_reg) - XW'(1));

    always_comb
    begin
        cap_next     = cap_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        status_next  = cdq_pkg::ST_OK;
        item_ok_next = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = tail_reg;
        rd_en        = 1'b0;
        rd_addr      = tail_reg;

        if (cfg_fire)
        begin
            cap_next   = cdq_pkg::eff_cap(cfg_data, DEPTH);
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end
        else if (accept)
        begin
            unique case (kind)
                cdq_pkg::KIND_PUSH_TAIL:
                begin
                    if (val_zero)
                    begin
                        status_next = cdq_pkg::ST_ZERO;
                    end
                    else if (q_full)
                    begin
                        status_next = cdq_pkg::ST_FULL;
                    end
                    else
                    begin
                        tail_next  = q_empty ? tail_reg : tail_inc;
                        wr_en      = 1'b1;
                        wr_addr    = tail_next;
                        count_next = count_reg + cdq_pkg::COUNT_W'(1);
                    end
                end
                cdq_pkg::KIND_PUSH_HEAD:
                begin
                    if (val_zero)
                    begin
                        status_next = cdq_pkg::ST_ZERO;
                    end
                    else if (q_full)
                    begin
                        status_next = cdq_pkg::ST_FULL;
                    end
                    else
                    begin
                        head_next  = q_empty ? head_reg : head_dec;
                        wr_en      = 1'b1;
                        wr_addr    = head_next;
                        count_next = count_reg + cdq_pkg::COUNT_W'(1);
                    end
                end
                cdq_pkg::KIND_POP_TAIL:
                begin
                    if (q_empty)
                    begin
                        status_next = cdq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        rd_en        = 1'b1;
                        rd_addr      = tail_reg;
                        item_ok_next = 1'b1;
                        if (tail_reg != head_reg)
                        begin
                            tail_next = tail_dec;
                        end
                        count_next = count_reg - cdq_pkg::COUNT_W'(1);
                    end
                end
                cdq_pkg::KIND_POP_HEAD:
                begin
                    if (q_empty)
                    begin
                        status_next = cdq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        rd_en        = 1'b1;
                        rd_addr      = head_reg;
                        item_ok_next = 1'b1;
                        if (head_reg != tail_reg)
                        begin
                            head_next = head_inc;
                        end
                        count_next = count_reg - cdq_pkg::COUNT_W'(1);
                    end
                end
                cdq_pkg::KIND_PEEK_TAIL:
                begin
                    if (q_empty)
                    begin
                        status_next = cdq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        rd_en        = 1'b1;
                        rd_addr      = tail_reg;
                        item_ok_next = 1'b1;
                    end
                end
                cdq_pkg::KIND_PEEK_HEAD:
                begin
                    if (q_empty)
                    begin
                        status_next = cdq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        rd_en        = 1'b1;
                        rd_addr      = head_reg;
                        item_ok_next = 1'b1;
                    end
                end
                default:
                begin
                    status_next = cdq_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= cdq_pkg::eff_cap(cdq_pkg::CAP_W'(cdq_pkg::CAP_RESET), DEPTH);
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
            status_reg  <= cdq_pkg::ST_OK;
            item_ok_reg <= 1'b0;
        end
        else
        begin
            cap_reg   <= cap_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            done_reg  <= accept;
            if (accept)
            begin
                status_reg  <= status_next;
                item_ok_reg <= item_ok_next;
            end
        end
    end

    cdq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ITEM_WIDTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign done     = done_reg;
    assign status   = status_reg;
    assign item_out = item_ok_reg ? rd_data : '0;
    assign count    = count_reg;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == cap_reg);

    `CDQ_ASSERT(a_count_le_cap, count_reg <= cap_reg, "fill count above capacity")
    `CDQ_ASSERT(a_ptrs_meet, (count_reg > cdq_pkg::COUNT_W'(1)) || (head_reg == tail_reg),
                "pointers apart with one item or none")
    `CDQ_ASSERT_NEXT(a_accept_done, accept, done_reg && !accept,
                     "accepted request gave no result")
    `CDQ_ASSERT(a_full_flag, !(done_reg && status_reg == cdq_pkg::ST_FULL) || is_full,
                "full refusal without full flag")

endmodule

@@ rtl/cdq_ram.sv @@
module cdq_ram #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
    parameter int WIDTH = cdq_pkg::ITEM_WIDTH_DEFAULT,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
